### src/pcpa_pkg.sv
package pcpa_pkg;

    localparam int CPU_COUNT  = 8;
    localparam int POOL_PAGES = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W  = 32;
    localparam int CPU_ID_W = 3;
    localparam int CPU_W   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PAGE_W  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int LINK_W  = PAGE_W + 1;
    localparam int OFS_W   = $clog2(PAGE_BYTES);
    localparam int PN_W    = ADDR_W - OFS_W;
    localparam int BASE_W  = PN_W + 1;
    localparam int CFG_IDX_W = 2;

    typedef logic [CPU_W-1:0]  cpu_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [LINK_W-1:0] link_t;

    // A head or link at or above POOL_PAGES marks the end of a list.
    localparam link_t NIL_LINK = LINK_W'(POOL_PAGES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADR = 2'd1;
    localparam logic [1:0] STATUS_NO_MEM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = CFG_IDX_W'(1);

    localparam logic [ADDR_W-1:0] LOWER_LIMIT_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] UPPER_LIMIT_RST = 32'h8800_0000;

    typedef struct packed {
        logic load;         // capture the input transaction
        logic free_commit;  // push a valid free and emit its result
        logic read_issue;   // read the link of the selected head
        logic pop_commit;   // advance the head and emit the grant
        logic oom_emit;     // emit an out of memory result
    } pcpa_cmd_t;

    typedef struct packed {
        logic op_free;
        logic found;
        logic out_free;
    } pcpa_sts_t;

endpackage

### src/pcpa_ctrl.sv
module pcpa_ctrl
    import pcpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pcpa_sts_t sts,
    output pcpa_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.op_free) begin
                    if (sts.out_free) begin
                        cmd.free_commit = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else if (sts.found) begin
                    cmd.read_issue = 1'b1;
                    state_next     = ST_POP;
                end else if (sts.out_free) begin
                    cmd.oom_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_POP: begin
                if (sts.out_free) begin
                    cmd.pop_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/pcpa_dpath.sv
module pcpa_dpath
    import pcpa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pcpa_cmd_t            cmd,
    output pcpa_sts_t            sts,
    input  logic                 s_opcode,
    input  logic [CPU_ID_W-1:0]  s_cpu_id,
    input  logic [ADDR_W-1:0]    s_page_address,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [ADDR_W-1:0]    m_granted_address
);

    logic [ADDR_W-1:0] lower_reg;
    logic [ADDR_W-1:0] upper_reg;

    logic              op_reg;
    cpu_t              cpu_reg;
    logic [ADDR_W-1:0] addr_reg;

    link_t             head_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] nonempty;

    link_t             link_mem [POOL_PAGES];
    link_t             link_rdata_reg;
    cpu_t              src_reg;
    page_t             pop_idx_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [ADDR_W-1:0] m_granted_reg;

    cpu_t              first_cpu;
    cpu_t              sel_cpu;
    link_t             sel_head;

    logic [BASE_W-1:0] base_pg;
    logic [BASE_W-1:0] addr_pg;
    logic [BASE_W-1:0] diff_pg;
    logic [BASE_W-1:0] grant_pg;
    logic              free_ok;
    page_t             free_idx;
    logic              emit;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= LOWER_LIMIT_RST;
            upper_reg <= UPPER_LIMIT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_LOWER_LIMIT) begin
                lower_reg <= cfg_data;
            end
            if (cfg_index == CFG_UPPER_LIMIT) begin
                upper_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            cpu_reg  <= cpu_t'(s_cpu_id % CPU_COUNT);
            addr_reg <= s_page_address;
        end
    end

    always_comb begin
        for (int i = 0; i < CPU_COUNT; i++) begin
            nonempty[i] = head_reg[i] < NIL_LINK;
        end
    end

    // Lowest numbered non-empty list, used when the requester's list is empty.
    always_comb begin
        first_cpu = '0;
        for (int i = CPU_COUNT - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                first_cpu = cpu_t'(i);
            end
        end
    end

    assign sel_cpu  = (op_reg == OP_FREE || nonempty[cpu_reg]) ? cpu_reg : first_cpu;
    assign sel_head = head_reg[sel_cpu];

    // The pool starts at the lower limit rounded up to a page boundary.
    assign base_pg = {1'b0, lower_reg[ADDR_W-1:OFS_W]}
                   + BASE_W'(|lower_reg[OFS_W-1:0]);
    assign addr_pg = {1'b0, addr_reg[ADDR_W-1:OFS_W]};
    assign diff_pg = addr_pg - base_pg;

    assign free_ok = !(|addr_reg[OFS_W-1:0])
                   && (addr_reg >= lower_reg)
                   && (addr_reg < upper_reg)
                   && (diff_pg < BASE_W'(POOL_PAGES));
    assign free_idx = diff_pg[PAGE_W-1:0];

    assign grant_pg = base_pg + BASE_W'(pop_idx_reg);

    // List heads.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CPU_COUNT; i++) begin
                head_reg[i] <= NIL_LINK;
            end
        end else if (cmd.free_commit && free_ok) begin
            head_reg[cpu_reg] <= {1'b0, free_idx};
        end else if (cmd.pop_commit) begin
            head_reg[src_reg] <= (link_rdata_reg < NIL_LINK) ? link_rdata_reg : NIL_LINK;
        end
    end

    // Link store: one write for a push, one registered read for a pop.
    always_ff @(posedge aclk) begin
        if (cmd.free_commit && free_ok) begin
            link_mem[free_idx] <= sel_head;
        end
        if (cmd.read_issue) begin
            link_rdata_reg <= link_mem[sel_head[PAGE_W-1:0]];
            src_reg        <= sel_cpu;
            pop_idx_reg    <= sel_head[PAGE_W-1:0];
        end
    end

    assign emit = cmd.free_commit || cmd.pop_commit || cmd.oom_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.free_commit) begin
            m_status_reg  <= free_ok ? STATUS_OK : STATUS_BAD_ADR;
            m_granted_reg <= '0;
        end else if (cmd.oom_emit) begin
            m_status_reg  <= STATUS_NO_MEM;
            m_granted_reg <= '0;
        end else if (cmd.pop_commit) begin
            m_status_reg  <= STATUS_OK;
            m_granted_reg <= {grant_pg[PN_W-1:0], OFS_W'(0)};
        end
    end

    assign sts.op_free  = (op_reg == OP_FREE);
    assign sts.found    = |nonempty;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_granted_reg;

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result written while the output register is still full");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read_issue |-> (sel_head < NIL_LINK))
        else $error("pop issued on an empty list");

    a_oom_all_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.oom_emit |-> (nonempty == '0))
        else $error("out of memory reported while a list holds pages");

    a_push_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.free_commit && free_ok) |=> (head_reg[$past(cpu_reg)] == {1'b0, $past(free_idx)}))
        else $error("pushed page is not the new list head");

endmodule

### src/per_cpu_page_allocator_core.sv
// Per-CPU page allocator: each CPU owns a LIFO free list kept as a head
// register plus a link store indexed by page number. A free pushes a page
// onto the named CPU's list after checking alignment, the lower/upper
// limits and the pool size; an allocate pops the requester's list or, if it
// is empty, the lowest numbered non-empty list, and reports out of memory
// when all are empty. One transaction is processed at a time: a free or an
// out-of-memory allocate has its result registered in the check state; an
// allocate that finds a page goes on to the pop state, where the registered
// read of the link store is ready, and has its result registered there. A
// state that registers a result waits while the output register is full and
// m_ready is low. A new transaction is accepted as soon as the previous
// result is in the output register, even if it is still waiting for m_ready.
// The link store powers up undefined and needs no clearing; fill the pool
// by freeing pages to CPU 0. Write the limit registers only while no
// transaction is in flight.
module per_cpu_page_allocator_core
    import pcpa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [CPU_ID_W-1:0]  s_cpu_id,
    input  logic [ADDR_W-1:0]    s_page_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [ADDR_W-1:0]    m_granted_address,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    pcpa_cmd_t cmd;
    pcpa_sts_t sts;

    assign cfg_ready = 1'b1;

    pcpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcpa_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_opcode          (s_opcode),
        .s_cpu_id          (s_cpu_id),
        .s_page_address    (s_page_address),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address)
    );

endmodule
